### hdl/ubx_pkg.sv
`timescale 1ns / 1ps

package ubx_pkg;

   // Frame constants
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;
   localparam logic [7:0] MAX_PAYLOAD = 8'd255;

   // Input item
   typedef struct packed {
      logic [7:0] msg_class;
      logic [7:0] msg_id;
      logic [7:0] payload_length;
      logic [7:0] payload_byte;
   } ubx_req_type;

   // Output byte
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } ubx_rsp_type;

   // Classified item, passed from front to back
   typedef struct packed {
      logic       first;
      logic       zero_len;
      logic       last;
      logic [7:0] msg_class;
      logic [7:0] msg_id;
      logic [7:0] length;
      logic [7:0] pbyte;
   } ubx_cmd_type;

   // Front status
   typedef struct packed {
      logic msg_open;
   } ubx_front_stat_type;

   // Back status
   typedef struct packed {
      logic mid_cmd;
      logic head_pop;
   } ubx_back_stat_type;

   // Back sequencer beats
   typedef enum logic [9:0] {
      PH_START   = 10'b00_0000_0001,
      PH_SYNC1   = 10'b00_0000_0010,
      PH_SYNC2   = 10'b00_0000_0100,
      PH_CLASS   = 10'b00_0000_1000,
      PH_ID      = 10'b00_0001_0000,
      PH_LENLO   = 10'b00_0010_0000,
      PH_LENHI   = 10'b00_0100_0000,
      PH_PAYLOAD = 10'b00_1000_0000,
      PH_CKA     = 10'b01_0000_0000,
      PH_CKB     = 10'b10_0000_0000
   } ubx_phase_type;

endpackage

### hdl/ubx_front.sv
`timescale 1ns / 1ps

module ubx_front
   import ubx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ubx_req_type        req_data,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output ubx_cmd_type        cmd_data,
   output ubx_front_stat_type stat
);

   logic [7:0] bytes_done_ff, bytes_done_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] len_sat;
   logic [8:0] done_next;
   logic       transfer;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign transfer  = req_valid && cmd_ready;
   assign stat.msg_open = (bytes_done_ff != 8'd0);

   // Classify the item against the open message
   always_comb begin
      len_sat = (req_data.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                        : req_data.payload_length;
      cmd_data.msg_class = req_data.msg_class;
      cmd_data.msg_id    = req_data.msg_id;
      cmd_data.pbyte     = req_data.payload_byte;
      bytes_done_in      = bytes_done_ff;
      held_in            = held_ff;
      if (bytes_done_ff == 8'd0) begin
         done_next         = 9'd1;
         cmd_data.first    = 1'b1;
         cmd_data.length   = len_sat;
         cmd_data.zero_len = (len_sat == 8'd0);
         cmd_data.last     = (len_sat <= 8'd1);
         if (transfer) begin
            held_in       = len_sat;
            bytes_done_in = cmd_data.last ? 8'd0 : 8'd1;
         end
      end else begin
         done_next         = {1'b0, bytes_done_ff} + 9'd1;
         cmd_data.first    = 1'b0;
         cmd_data.length   = held_ff;
         cmd_data.zero_len = 1'b0;
         cmd_data.last     = (done_next >= {1'b0, held_ff});
         if (transfer) begin
            bytes_done_in = cmd_data.last ? 8'd0 : done_next[7:0];
         end
      end
   end

   // Message tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_done_ff <= 8'd0;
         held_ff       <= 8'd0;
      end else begin
         bytes_done_ff <= bytes_done_in;
         held_ff       <= held_in;
      end
   end

endmodule

### hdl/ubx_cmd_fifo.sv
`timescale 1ns / 1ps

module ubx_cmd_fifo
   import ubx_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  ubx_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output ubx_cmd_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   ubx_cmd_type   mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### hdl/ubx_back.sv
`timescale 1ns / 1ps

module ubx_back
   import ubx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ubx_cmd_type       cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ubx_rsp_type       rsp_data,
   output ubx_back_stat_type stat
);

   ubx_phase_type phase_ff, phase_in, cur;
   logic [7:0]    sum_a_ff, sum_a_in;
   logic [7:0]    sum_b_ff, sum_b_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ubx_rsp_type   rsp_ff, rsp_in;
   logic [7:0]    beat_byte;
   logic          beat_end, beat_summed, beat_done;
   ubx_phase_type beat_next;
   logic          can_emit, fire;

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign fire      = cmd_valid && can_emit;
   assign cmd_ready = fire && beat_done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign stat.mid_cmd  = (phase_ff != PH_START);
   assign stat.head_pop = cmd_ready;

   // Beat decode for the command at the queue head
   always_comb begin
      if (phase_ff == PH_START) cur = cmd_data.first ? PH_SYNC1 : PH_PAYLOAD;
      else cur = phase_ff;
      beat_byte   = 8'd0;
      beat_end    = 1'b0;
      beat_summed = 1'b0;
      beat_done   = 1'b0;
      beat_next   = PH_START;
      case (cur)
         PH_SYNC1: begin
            beat_byte = SYNC_FIRST;
            beat_next = PH_SYNC2;
         end
         PH_SYNC2: begin
            beat_byte = SYNC_SECOND;
            beat_next = PH_CLASS;
         end
         PH_CLASS: begin
            beat_byte   = cmd_data.msg_class;
            beat_summed = 1'b1;
            beat_next   = PH_ID;
         end
         PH_ID: begin
            beat_byte   = cmd_data.msg_id;
            beat_summed = 1'b1;
            beat_next   = PH_LENLO;
         end
         PH_LENLO: begin
            beat_byte   = cmd_data.length;
            beat_summed = 1'b1;
            beat_next   = PH_LENHI;
         end
         PH_LENHI: begin
            beat_byte   = 8'd0;
            beat_summed = 1'b1;
            beat_next   = cmd_data.zero_len ? PH_CKA : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            beat_byte   = cmd_data.pbyte;
            beat_summed = 1'b1;
            beat_done   = !cmd_data.last;
            beat_next   = cmd_data.last ? PH_CKA : PH_START;
         end
         PH_CKA: begin
            beat_byte = sum_a_ff;
            beat_next = PH_CKB;
         end
         PH_CKB: begin
            beat_byte = sum_b_ff;
            beat_end  = 1'b1;
            beat_done = 1'b1;
            beat_next = PH_START;
         end
         default: begin
            beat_next = PH_START;
         end
      endcase
   end

   // Sequencer, running sums and output register
   always_comb begin
      phase_in     = phase_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         phase_in            = beat_next;
         rsp_valid_in        = 1'b1;
         rsp_in.frame_byte   = beat_byte;
         rsp_in.frame_end    = beat_end;
         if (cur inside {PH_SYNC1, PH_CKB}) begin
            sum_a_in = 8'd0;
            sum_b_in = 8'd0;
         end else if (beat_summed) begin
            sum_a_in = sum_a_ff + beat_byte;
            sum_b_in = sum_b_ff + sum_a_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         sum_a_ff     <= 8'd0;
         sum_b_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

### hdl/ubx_frame_builder.sv
`timescale 1ns / 1ps

// Binary receiver-protocol frame builder. Each req transfer carries one
// payload byte; the first item of a message also gives class, id and length
// (capped at 255). The block sends sync 0xB5 0x62, class, id, length low,
// length high (0), the payload bytes and the two Fletcher-8 sums, one byte
// per rsp transfer, with frame_end set on the last sum byte. A continuing
// payload item gives one output byte; an item that opens a message gives
// the header and its byte, a zero-length one the header and both sums, and
// a closing item adds both sums. The output register of the back sequencer
// sends one byte per cycle while the receiver is ready, and a small command
// queue lets items be accepted while header and checksum beats are still
// going out.
module ubx_frame_builder
   import ubx_pkg::*;
#(
   parameter int CMD_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ubx_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ubx_rsp_type rsp_data
);

   logic               fc_valid, fc_ready;
   ubx_cmd_type        fc_data;
   logic               bc_valid, bc_ready;
   ubx_cmd_type        bc_data;
   ubx_front_stat_type front_stat;
   ubx_back_stat_type  back_stat;

   // Front: classify items
   ubx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (fc_valid),
      .cmd_ready (fc_ready),
      .cmd_data  (fc_data),
      .stat      (front_stat)
   );

   // Command queue
   ubx_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fc_valid),
      .push_ready (fc_ready),
      .push_data  (fc_data),
      .pop_valid  (bc_valid),
      .pop_ready  (bc_ready),
      .pop_data   (bc_data)
   );

   // Back: emit frame bytes
   ubx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (bc_valid),
      .cmd_ready (bc_ready),
      .cmd_data  (bc_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .stat      (back_stat)
   );

   // A queued command always yields an output byte once the register frees
   a_back_progress: assert property (@(posedge clock) disable iff (reset)
      (bc_valid && (!rsp_valid || rsp_ready)) |=> rsp_valid)
      else $error("back stalled with a command and a free output register");

   // The head stays queued while its beats are in flight
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      back_stat.mid_cmd |-> bc_valid)
      else $error("back mid-command with an empty queue");

   // An opening item of a multi-byte message leaves the front with it open
   a_front_open: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && fc_data.first && !fc_data.last)
      |=> front_stat.msg_open)
      else $error("front did not open the message");

   // The head pops only on its command's last beat, which loads an output byte
   a_pop_beat: assert property (@(posedge clock) disable iff (reset)
      back_stat.head_pop |=> rsp_valid)
      else $error("head popped without an output byte");

endmodule

### verif/ubx_frame_builder_tb.sv
`timescale 1ns / 1ps

module ubx_frame_builder_tb;
   import ubx_pkg::*;

   localparam int RANDOM_ITEMS = 136;
   localparam int LONG_MSG_IDX = 5;
   localparam int LONG_LEN     = 60;
   localparam int LONG_HOLD    = 250;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 200000;

   // One row of directed stimulus; typed bytes, when present, form a whole frame
   typedef struct packed {
      ubx_req_type      req;
      logic [3:0]       n_typed;
      logic [0:8][7:0]  typed;
   } stim_row_type;

   localparam int N_DIRECTED = 14;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // all-zero header, zero length: sums stay zero
      '{'{8'h00, 8'h00, 8'h00, 8'h00}, 4'd8,
        {8'hB5, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
      // all-zero header, one zero payload byte: sum A 1, sum B 3
      '{'{8'h00, 8'h00, 8'h01, 8'h00}, 4'd9,
        {8'hB5, 8'h62, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h03}},
      // zero length, payload byte ignored
      '{'{8'hFF, 8'hFF, 8'h00, 8'hFF}, 4'd0, '0},
      '{'{8'hFF, 8'hFF, 8'h01, 8'hFF}, 4'd0, '0},
      // two bytes; header fields on the second item are ignored
      '{'{8'hA5, 8'h5A, 8'h02, 8'h00}, 4'd0, '0},
      '{'{8'h00, 8'hFF, 8'hFF, 8'hFF}, 4'd0, '0},
      '{'{8'h12, 8'h34, 8'h03, 8'hAA}, 4'd0, '0},
      '{'{8'hFF, 8'h00, 8'h00, 8'h55}, 4'd0, '0},
      '{'{8'h00, 8'h00, 8'h80, 8'h80}, 4'd0, '0},
      '{'{8'h06, 8'h01, 8'h04, 8'h01}, 4'd0, '0},
      '{'{8'h55, 8'hAA, 8'h00, 8'h02}, 4'd0, '0},
      '{'{8'hAA, 8'h55, 8'h01, 8'h04}, 4'd0, '0},
      '{'{8'h0F, 8'hF0, 8'h7F, 8'h08}, 4'd0, '0},
      // back-to-back zero-length frame after a close
      '{'{8'h01, 8'h02, 8'h00, 8'h33}, 4'd0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ubx_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ubx_rsp_type rsp_data;

   // Frame predictor state
   logic [7:0] open_count = '0;
   logic [7:0] run_a = '0;
   logic [7:0] run_b = '0;
   logic [7:0] open_len = '0;

   ubx_rsp_type frame_bytes_q[$];
   int          fail_count = 0;
   int          send_calm = 0;
   int          cycle_count = 0;

   ubx_frame_builder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Wait draw: mostly a uniform random wait, with occasional runs of no waiting at all
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // Byte covered by both Fletcher sums
   function automatic void put_summed(input logic [7:0] b, ref ubx_rsp_type bytes[$]);
      run_a = run_a + b;
      run_b = run_b + run_a;
      bytes.push_back('{frame_byte: b, frame_end: 1'b0});
   endfunction

   // CK_A, CK_B, then the message is closed
   function automatic void put_checksum(ref ubx_rsp_type bytes[$]);
      bytes.push_back('{frame_byte: run_a, frame_end: 1'b0});
      bytes.push_back('{frame_byte: run_b, frame_end: 1'b1});
      open_count = '0;
      run_a      = '0;
      run_b      = '0;
      open_len   = '0;
   endfunction

   // Frame bytes caused by one accepted item
   function automatic void predict_frame(input ubx_req_type req, ref ubx_rsp_type bytes[$]);
      if (open_count == 0) begin
         open_len = req.payload_length;
         if (open_len > MAX_PAYLOAD) open_len = MAX_PAYLOAD;
         run_a = '0;
         run_b = '0;
         bytes.push_back('{frame_byte: SYNC_FIRST, frame_end: 1'b0});
         bytes.push_back('{frame_byte: SYNC_SECOND, frame_end: 1'b0});
         put_summed(req.msg_class, bytes);
         put_summed(req.msg_id, bytes);
         put_summed(open_len, bytes);
         put_summed(8'h00, bytes);
         if (open_len == 0) begin
            put_checksum(bytes);
            return;
         end
      end
      put_summed(req.payload_byte, bytes);
      open_count = open_count + 8'd1;
      if (open_count >= open_len) put_checksum(bytes);
   endfunction

   // Offer one item, wait for its transfer, then queue the bytes it causes
   task automatic offer_item(input ubx_req_type item, input logic [3:0] n_typed,
                             input logic [0:8][7:0] typed);
      int gap;
      ubx_rsp_type predicted[$];
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_frame(item, predicted);
      if (n_typed == 0) begin
         foreach (predicted[i]) frame_bytes_q.push_back(predicted[i]);
      end else begin
         // typed rows are whole frames: end flag on the last typed byte
         for (int i = 0; i < n_typed; i++)
            frame_bytes_q.push_back('{frame_byte: typed[i], frame_end: (i == n_typed - 1)});
      end
   endtask

   // Receiver: random ready, with long hold-offs to back up the block
   initial begin : frame_sink
      int hold;
      int calm;
      int taken;
      calm  = 0;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 40 || taken == 900) hold = LONG_HOLD;
         else hold = draw_wait(calm);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Compare each rsp transfer with the oldest expected byte
   always @(posedge clock) begin : byte_check
      ubx_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_q.size() == 0) begin
            $error("frame_byte %02h arrived with no byte expected", rsp_data.frame_byte);
            fail_count++;
         end else begin
            want = frame_bytes_q.pop_front();
            if (rsp_data.frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %02h, got %02h",
                      want.frame_byte, rsp_data.frame_byte);
               fail_count++;
            end
            if (rsp_data.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b",
                      want.frame_end, rsp_data.frame_end);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("ubx_frame_builder test failed");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      ubx_req_type item;
      int          sent;
      int          msg_idx;
      int          len;
      int          k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < N_DIRECTED; r++)
         offer_item(DIRECTED[r].req, DIRECTED[r].n_typed, DIRECTED[r].typed);

      // random whole messages; continuing items carry noise in the ignored fields
      sent    = 0;
      msg_idx = 0;
      while (sent < RANDOM_ITEMS) begin
         if (msg_idx == LONG_MSG_IDX) len = LONG_LEN;
         else if ($urandom_range(0, 19) == 0) len = $urandom_range(9, 80);
         else len = $urandom_range(0, 6);
         // keep the item total within the budget
         if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
         item = ubx_req_type'($urandom);
         item.payload_length = len[7:0];
         offer_item(item, 4'd0, '0);
         sent++;
         for (k = 1; k < len; k++) begin
            item = ubx_req_type'($urandom);
            offer_item(item, 4'd0, '0);
            sent++;
         end
         msg_idx++;
      end
      req_valid <= 1'b0;

      // drain, then a short tail to catch stray bytes
      while (frame_bytes_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ubx_frame_builder test passed");
      end else begin
         $display("ubx_frame_builder test failed");
      end
      $finish;
   end

endmodule
